@@ src/color_fade_sequencer_assert.svh @@
// ----------------------------------------------------------------------------
// color fade sequencer assertion macros
// shared property shapes, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef COLOR_FADE_SEQUENCER_ASSERT_SVH
`define COLOR_FADE_SEQUENCER_ASSERT_SVH

// condition implies consequence in the same cycle
`define CFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("color fade sequencer check failed");

// condition implies consequence in the next cycle
`define CFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("color fade sequencer check failed");

`endif

@@ src/cfs_pkg.sv @@
// ----------------------------------------------------------------------------
// cfs_pkg
// shared widths, types, register indexes and control structs of the fader
// ----------------------------------------------------------------------------
package cfs_pkg;

  // step counter width and derived datapath widths
  localparam int STEP_BITS  = 16;
  localparam int COLOR_W    = 8;
  localparam int MUL_W      = COLOR_W + STEP_BITS;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int STEP_CFG_W = 16;

  typedef logic [STEP_BITS-1:0]  step_t;
  typedef logic [COLOR_W-1:0]    color_t;
  typedef logic [MUL_W-1:0]      mul_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_COLOR_START = 2'd0;
  localparam cfg_idx_t REG_COLOR_END   = 2'd1;
  localparam cfg_idx_t REG_STEP_COUNT  = 2'd2;

  // component select codes
  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;

  localparam step_t  STEP_RESET = step_t'(300);
  localparam color_t ROOT_MSB   = {1'b1, {(COLOR_W-1){1'b0}}};

  // request to the root engine
  typedef struct packed {
    logic   start;
    color_t a;
    color_t b;
    step_t  n;
    step_t  i;
    step_t  s;
  } root_req_t;

  // response from the root engine
  typedef struct packed {
    logic   done;
    color_t root;
  } root_rsp_t;

endpackage

@@ src/cfs_mul.sv @@
// ----------------------------------------------------------------------------
// cfs_mul
// shared unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
module cfs_mul (
  input  logic          clk,
  input  cfs_pkg::mul_t  op_a,
  input  cfs_pkg::mul_t  op_b,
  output cfs_pkg::prod_t prod_r
);

  // one product per cycle
  always_ff @(posedge clk) begin
    prod_r <= cfs_pkg::prod_t'(op_a) * cfs_pkg::prod_t'(op_b);
  end

endmodule

@@ src/cfs_root.sv @@
// ----------------------------------------------------------------------------
// cfs_root
// one blended component: builds (a*n)^2 + (b*i)^2, then finds the largest r
// with 2*(r*s)^2 <= sum, one root bit per trial, square and compare passes
// ----------------------------------------------------------------------------
`include "color_fade_sequencer_assert.svh"

module cfs_root (
  input  logic               clk,
  input  logic               rst_n,
  input  cfs_pkg::root_req_t req,
  output cfs_pkg::root_rsp_t rsp
);

  typedef enum logic [8:0] {
    C_IDLE = 9'b000000001,
    C_AN   = 9'b000000010,
    C_ASQ  = 9'b000000100,
    C_BI   = 9'b000001000,
    C_BSQ  = 9'b000010000,
    C_SUM  = 9'b000100000,
    C_TS   = 9'b001000000,
    C_TSQ  = 9'b010000000,
    C_CMP  = 9'b100000000
  } core_st_t;

  core_st_t        state_r, state_nxt;
  cfs_pkg::color_t bit_r, bit_nxt;
  cfs_pkg::color_t r_r, r_nxt;
  cfs_pkg::sum_t   acc_r, acc_nxt;
  logic            done_r, done_nxt;
  cfs_pkg::mul_t   op_a, op_b;
  cfs_pkg::prod_t  prod_r;
  cfs_pkg::color_t trial;
  cfs_pkg::mul_t   prod_lo;
  logic            fits;

  cfs_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign trial   = r_r | bit_r;
  assign prod_lo = prod_r[cfs_pkg::MUL_W-1:0];
  assign fits    = {prod_r, 1'b0} <= acc_r;

  // multiplier operand select
  always_comb begin
    unique case (state_r)
      C_AN: begin
        op_a = cfs_pkg::mul_t'(req.a);
        op_b = cfs_pkg::mul_t'(req.n);
      end
      C_BI: begin
        op_a = cfs_pkg::mul_t'(req.b);
        op_b = cfs_pkg::mul_t'(req.i);
      end
      C_TS: begin
        op_a = cfs_pkg::mul_t'(trial);
        op_b = cfs_pkg::mul_t'(req.s);
      end
      C_ASQ, C_BSQ, C_TSQ: begin
        op_a = prod_lo;
        op_b = prod_lo;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    r_nxt     = r_r;
    acc_nxt   = acc_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      C_IDLE: begin
        if (req.start) begin
          state_nxt = C_AN;
        end
      end
      C_AN:  state_nxt = C_ASQ;
      C_ASQ: state_nxt = C_BI;
      C_BI: begin
        acc_nxt   = cfs_pkg::sum_t'(prod_r);
        state_nxt = C_BSQ;
      end
      C_BSQ: state_nxt = C_SUM;
      C_SUM: begin
        acc_nxt   = acc_r + cfs_pkg::sum_t'(prod_r);
        r_nxt     = '0;
        bit_nxt   = cfs_pkg::ROOT_MSB;
        state_nxt = C_TS;
      end
      C_TS:  state_nxt = C_TSQ;
      C_TSQ: state_nxt = C_CMP;
      C_CMP: begin
        if (fits) begin
          r_nxt = trial;
        end
        if (bit_r[0]) begin
          bit_nxt   = cfs_pkg::ROOT_MSB;
          done_nxt  = 1'b1;
          state_nxt = C_IDLE;
        end else begin
          bit_nxt   = bit_r >> 1;
          state_nxt = C_TS;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      bit_r   <= cfs_pkg::ROOT_MSB;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = r_r;

  // checks
  `CFS_ASSERT_IMP(a_bit_onehot, 1'b1, $onehot(bit_r))
  `CFS_ASSERT_IMP(a_start_when_idle, req.start, state_r == C_IDLE)
  `CFS_ASSERT_IMP(a_done_rearmed, rsp.done, (state_r == C_IDLE) && (bit_r == cfs_pkg::ROOT_MSB))

endmodule

@@ src/color_fade_sequencer.sv @@
// ----------------------------------------------------------------------------
// color_fade_sequencer
// two-color fade generator: one blended RGB color per in-range tick request
// ----------------------------------------------------------------------------
// an accepted request runs the three components in turn on the one shared
// multiplier (start, sum passes, a trial, square and compare pass for each of
// the eight root bits, handoff), then loads the output and raises out_valid
// once no older result waits. in_ready stays low until that load, so no new
// request is taken meanwhile; a request giving no result starts nothing.
// reset is synchronous: colors clear, step count is 300, step index clears.
// ----------------------------------------------------------------------------
`include "color_fade_sequencer_assert.svh"

module color_fade_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  cfs_pkg::cfg_idx_t    cfg_index,
  input  cfs_pkg::cfg_data_t   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_red_out,
  output logic [7:0]           out_green_out,
  output logic [7:0]           out_blue_out,
  output logic                 out_final_step
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } st_t;

  st_t                state_r, state_nxt;
  logic [1:0]         comp_r, comp_nxt;
  logic               start_r, start_nxt;
  cfs_pkg::step_t     idx_r, idx_nxt;
  cfs_pkg::step_t     i_r, i_nxt;
  cfs_pkg::step_t     n_r, n_nxt;
  logic               final_r, final_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               load_out;
  cfs_pkg::color_t    red_r, green_r, blue_r;
  cfs_pkg::color_t    out_red_r, out_green_r, out_blue_r;
  logic               out_final_r;
  logic [23:0]        color_start_r;
  logic [23:0]        color_end_r;
  cfs_pkg::step_t     step_count_r;
  cfs_pkg::step_t     idx_eff;
  cfs_pkg::step_t     n_eff;
  logic               in_acc;
  logic               go;
  cfs_pkg::root_req_t req;
  cfs_pkg::root_rsp_t rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_start_r <= '0;
      color_end_r   <= '0;
      step_count_r  <= cfs_pkg::STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfs_pkg::REG_COLOR_START: color_start_r <= cfg_wdata[23:0];
        cfs_pkg::REG_COLOR_END:   color_end_r   <= cfg_wdata[23:0];
        cfs_pkg::REG_STEP_COUNT:
          step_count_r <= cfs_pkg::step_t'(cfg_wdata[cfs_pkg::STEP_CFG_W-1:0]);
        default: ;
      endcase
    end
  end

  // request decode
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign idx_eff  = in_restart ? '0 : idx_r;
  assign go       = idx_eff < step_count_r;
  assign n_eff    = step_count_r - idx_eff;

  // component operands for the root engine
  always_comb begin
    req.start = start_r;
    req.n     = n_r;
    req.i     = i_r;
    req.s     = step_count_r;
    unique case (comp_r)
      cfs_pkg::COMP_RED: begin
        req.a = color_start_r[23:16];
        req.b = color_end_r[23:16];
      end
      cfs_pkg::COMP_GREEN: begin
        req.a = color_start_r[15:8];
        req.b = color_end_r[15:8];
      end
      default: begin
        req.a = color_start_r[7:0];
        req.b = color_end_r[7:0];
      end
    endcase
  end

  cfs_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // step sequencer
  always_comb begin
    state_nxt     = state_r;
    comp_nxt      = comp_r;
    start_nxt     = 1'b0;
    idx_nxt       = idx_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    load_out      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt = idx_eff;
          if (go) begin
            state_nxt = ST_RUN;
            comp_nxt  = cfs_pkg::COMP_RED;
            start_nxt = 1'b1;
            i_nxt     = idx_eff;
            n_nxt     = n_eff;
            final_nxt = (n_eff == cfs_pkg::step_t'(1));
          end
        end
      end
      ST_RUN: begin
        if (rsp.done) begin
          if (comp_r == cfs_pkg::COMP_BLUE) begin
            state_nxt = ST_HOLD;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            start_nxt = 1'b1;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          idx_nxt       = i_r + cfs_pkg::step_t'(1);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      comp_r      <= cfs_pkg::COMP_RED;
      start_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      comp_r      <= comp_nxt;
      start_r     <= start_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // step operands
  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    final_r <= final_nxt;
  end

  // component capture
  always_ff @(posedge clk) begin
    if (rsp.done) begin
      unique case (comp_r)
        cfs_pkg::COMP_RED:   red_r   <= rsp.root;
        cfs_pkg::COMP_GREEN: green_r <= rsp.root;
        default:             blue_r  <= rsp.root;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_red_r   <= red_r;
      out_green_r <= green_r;
      out_blue_r  <= blue_r;
      out_final_r <= final_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_out    = out_red_r;
  assign out_green_out  = out_green_r;
  assign out_blue_out   = out_blue_r;
  assign out_final_step = out_final_r;

  // checks
  `CFS_ASSERT_IMP(a_done_in_run, rsp.done, state_r == ST_RUN)
  `CFS_ASSERT_NXT(a_hold_loads, (state_r == ST_HOLD) && (!out_valid_r || out_ready), out_valid_r && (state_r == ST_IDLE))
  `CFS_ASSERT_NXT(a_step_advances, load_out, idx_r == i_r + cfs_pkg::step_t'(1))

endmodule

@@ sim/fade_color_checker.sv @@
// ----------------------------------------------------------------------------
// fade_color_checker
// watches the register port and the request and result channels of the fader,
// keeps its own copy of the registers and step index, predicts each blended
// color and compares every accepted result against the oldest prediction
// ----------------------------------------------------------------------------
module fade_color_checker
  import cfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_index,
  input  cfg_data_t  cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_restart,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_red_out,
  input  logic [7:0] out_green_out,
  input  logic [7:0] out_blue_out,
  input  logic       out_final_step,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
    logic   last;
  } fade_color_t;

  // shadow registers and step position
  cfg_data_t          start_color;
  cfg_data_t          end_color;
  step_t              fade_len;
  logic [STEP_BITS:0] step_pos;

  fade_color_t expected_colors[$];

  // largest r with 2*(r*s)^2 <= (a*n)^2 + (b*i)^2
  function automatic color_t blend_root(color_t a, color_t b, logic [STEP_BITS:0] n,
                                        logic [STEP_BITS:0] i, step_t s);
    logic [63:0] an;
    logic [63:0] bi;
    logic [63:0] energy;
    logic [63:0] x;
    color_t      r;
    color_t      t;
    an     = 64'(a) * 64'(n);
    bi     = 64'(b) * 64'(i);
    energy = an * an + bi * bi;
    r      = '0;
    for (int bit_pos = COLOR_W - 1; bit_pos >= 0; bit_pos--) begin
      t = r | color_t'(1 << bit_pos);
      x = 64'(t) * 64'(s);
      if (2 * x * x <= energy) begin
        r = t;
      end
    end
    return r;
  endfunction

  // next color of the fade at the current position
  function automatic fade_color_t next_fade_color();
    fade_color_t        c;
    logic [STEP_BITS:0] n;
    n       = {1'b0, fade_len} - step_pos;
    c.red   = blend_root(start_color[23:16], end_color[23:16], n, step_pos, fade_len);
    c.green = blend_root(start_color[15:8], end_color[15:8], n, step_pos, fade_len);
    c.blue  = blend_root(start_color[7:0], end_color[7:0], n, step_pos, fade_len);
    c.last  = (step_pos == {1'b0, fade_len} - 1);
    return c;
  endfunction

  always @(posedge clk) begin
    fade_color_t want;
    if (!rst_n) begin
      start_color = '0;
      end_color   = '0;
      fade_len    = STEP_RESET;
      step_pos    = '0;
      fail_count  = 0;
      expected_colors.delete();
    end else begin
      // result side: compare against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $error("out_valid: result with no request pending (r %0d g %0d b %0d)",
                 out_red_out, out_green_out, out_blue_out);
          fail_count++;
        end else begin
          want = expected_colors.pop_front();
          if (out_red_out !== want.red) begin
            $error("red_out: expected %0d, actual %0d", want.red, out_red_out);
            fail_count++;
          end
          if (out_green_out !== want.green) begin
            $error("green_out: expected %0d, actual %0d", want.green, out_green_out);
            fail_count++;
          end
          if (out_blue_out !== want.blue) begin
            $error("blue_out: expected %0d, actual %0d", want.blue, out_blue_out);
            fail_count++;
          end
          if (out_final_step !== want.last) begin
            $error("final_step: expected %0d, actual %0d", want.last, out_final_step);
            fail_count++;
          end
        end
      end

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_COLOR_START: start_color = cfg_wdata;
          REG_COLOR_END:   end_color   = cfg_wdata;
          REG_STEP_COUNT:  fade_len    = step_t'(cfg_wdata[STEP_CFG_W-1:0]);
          default: ;
        endcase
      end

      // request side: advance the fade and predict
      if (in_valid && in_ready) begin
        if (in_restart) begin
          step_pos = '0;
        end
        if (fade_len != 0 && step_pos < {1'b0, fade_len}) begin
          expected_colors.push_back(next_fade_color());
          step_pos = step_pos + 1;
        end
      end
    end
    pending = expected_colors.size();
  end

endmodule

@@ sim/tb_color_fade_sequencer.sv @@
// ----------------------------------------------------------------------------
// tb_color_fade_sequencer
// drives frame tick requests and register settings into the fader with
// random idling on both channels; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_color_fade_sequencer;
  import cfs_pkg::*;

  localparam int       ITEMS_TOTAL    = 1550;
  localparam int       DRAIN_CYCLES   = 120;
  localparam int       TIMEOUT_CYCLES = 3_000_000;
  localparam cfg_idx_t REG_UNUSED     = 2'd3;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_we      = 1'b0;
  cfg_idx_t   cfg_index   = '0;
  cfg_data_t  cfg_wdata   = '0;
  logic       in_valid    = 1'b0;
  logic       in_restart  = 1'b0;
  logic       out_ready   = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;
  logic       out_final_step;

  int fail_count;
  int pending;
  int ticks_sent    = 0;
  int in_idle_pct   = 20;
  int out_stall_pct = 59;

  always #4 clk = ~clk;

  color_fade_sequencer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_final_step (out_final_step)
  );

  fade_color_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_final_step (out_final_step),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // result side backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // one tick request; valid stays high into the next request unless a gap is rolled
  task automatic send_tick(input logic restart);
    if (ticks_sent < ITEMS_TOTAL / 3) begin
      in_idle_pct   = 20;
      out_stall_pct = 59;
    end else if (ticks_sent < 2 * ITEMS_TOTAL / 3) begin
      in_idle_pct   = 59;
      out_stall_pct = 20;
    end else begin
      in_idle_pct   = 0;
      out_stall_pct = 0;
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
  endtask

  // hold the sender until every predicted color has come back and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all registers back to back, optionally followed by a stray index
  task automatic write_config(input cfg_data_t start_c, input cfg_data_t end_c,
                              input cfg_data_t count_word, input bit stray);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLOR_START;
    cfg_wdata <= start_c;
    @(posedge clk);
    cfg_index <= REG_COLOR_END;
    cfg_wdata <= end_c;
    @(posedge clk);
    cfg_index <= REG_STEP_COUNT;
    cfg_wdata <= count_word;
    @(posedge clk);
    if (stray) begin
      cfg_index <= REG_UNUSED;
      cfg_wdata <= cfg_data_t'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // random color with extra weight on dark and saturated components
  function automatic cfg_data_t pick_color();
    cfg_data_t c;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(9))
        0:       c[k*8 +: 8] = 8'h00;
        1:       c[k*8 +: 8] = 8'hff;
        default: c[k*8 +: 8] = 8'($urandom);
      endcase
    end
    return c;
  endfunction

  // mostly short fades, a few empty or very long ones
  function automatic step_t pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5)       return '0;
    else if (roll < 8)  return '1;
    else if (roll < 12) return step_t'($urandom);
    else if (roll < 70) return step_t'($urandom_range(1, 8));
    else                return step_t'($urandom_range(9, 40));
  endfunction

  initial begin
    step_t len;
    int    phase_end;
    int    run_len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: black fade over 300 steps
    send_tick(1'b0);
    send_tick(1'b1);

    // white to black over three steps, run past the end and restart
    write_config(24'hffffff, 24'h000000, 24'd3, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);

    // count lowered to the index, then a one-step fade
    write_config(24'h000000, 24'hffffff, 24'd1, 1'b0);
    send_tick(1'b0);
    send_tick(1'b1);

    // zero step count, plus a write to the unused index
    write_config(24'h123456, 24'hfedcba, 24'hab0000, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);

    // longest fade with full white on both ends
    write_config(24'hffffff, 24'hffffff, 24'h00ffff, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    // count lowered to the index, then raised so the fade goes on
    write_config(24'hff00ff, 24'h00ff00, 24'd2, 1'b0);
    send_tick(1'b0);
    write_config(24'hff00ff, 24'h00ff00, 24'hff0005, 1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);

    // random phases: restart followed by a run of ticks, with some noise
    while (ticks_sent < ITEMS_TOTAL) begin
      len = pick_length();
      write_config(pick_color(), pick_color(), {8'($urandom), len}, $urandom_range(3) == 0);
      phase_end = ticks_sent + $urandom_range(30, 60);
      while (ticks_sent < phase_end && ticks_sent < ITEMS_TOTAL) begin
        send_tick($urandom_range(9) != 0);
        run_len = $urandom_range(0, (len < 60) ? int'(len) + 1 : 60);
        for (int k = 0; k < run_len && ticks_sent < phase_end; k++) begin
          send_tick($urandom_range(99) < 3);
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("FAILURE");
    $finish;
  end

endmodule
